/* src/mfpcc_pkg.sv */
// Package for the magic-framed packet CRC check unit.
// Holds the frame geometry defaults, the CRC-16 XMODEM constants and the byte-wise CRC update.
// No dependencies.
`default_nettype none

package mfpcc_pkg;

	localparam int HEADER_BYTES_DEF  = 4;
	localparam int PAYLOAD_BYTES_DEF = 10;

	localparam int BYTE_W  = 8;
	localparam int CRC_W   = 16;
	localparam int COORD_W = 32;

	localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

	// Field layout of the result transaction
	localparam int OUT_BITS   = 1 + COORD_W + COORD_W + CRC_W;
	localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

	// CRC-16 XMODEM, MSB first, one byte
	function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
		input logic [BYTE_W-1:0] b);
		logic [CRC_W-1:0] c;
		c = crc ^ {b, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[CRC_W-1]) begin
				c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[CRC_W-2:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

/* src/magic_framed_packet_crc_check_unit.sv */
// Magic-framed packet receiver with CRC-16 XMODEM check, top level.
// The last CRC byte passes the input register (byte_s1) and then the result register (m_data_q) to m_tvalid.
// Throughput: one byte per cycle, set by the single-byte CRC update between the two registers;
// a result waiting on m_tready holds every following byte in the input register.
// A frame result appears only on the last CRC byte; all other bytes give no transaction.
// Reset (arst_n, async low): hunting for magic, CRC and coordinates cleared, magic byte 0.
// Depends on mfpcc_pkg.
`default_nettype none

module magic_framed_packet_crc_check_unit
	import mfpcc_pkg::*;
#(
	parameter int HEADER_BYTES  = HEADER_BYTES_DEF,
	parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write channel: magic_byte[7:0]
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [BYTE_W-1:0]     cfg_data,
	// input stream, s_tdata: rx_byte[7:0]
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [BYTE_W-1:0]     s_tdata,
	// result stream, m_tdata: frame_status[0], latitude[32:1], longitude[64:33],
	// computed_crc[80:65], zero fill[87:81]
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic [OUT_DATA_W-1:0]      m_tdata
);

	localparam int DATA_BYTES = HEADER_BYTES + PAYLOAD_BYTES;
	localparam int LAT_OFFSET = HEADER_BYTES + 2;
	localparam int LON_OFFSET = HEADER_BYTES + 6;
	localparam int POS_W      = $clog2(DATA_BYTES + 2);

	localparam logic [POS_W-1:0] DATA_POS = POS_W'(DATA_BYTES);
	localparam logic [POS_W-1:0] LAST_POS = POS_W'(DATA_BYTES + 1);

	logic [BYTE_W-1:0]     magic_q;
	logic                  valid_s1;
	logic [BYTE_W-1:0]     byte_s1;
	logic [POS_W-1:0]      pos_q;
	logic [CRC_W-1:0]      crc_q;
	logic [COORD_W-1:0]    lat_q;
	logic [COORD_W-1:0]    lon_q;
	logic [BYTE_W-1:0]     crc_lo_q;
	logic                  m_valid_q;
	logic [OUT_DATA_W-1:0] m_data_q;

	logic                  advance;
	logic                  is_data;
	logic                  emit;
	logic [POS_W-1:0]      pos_d;
	logic [CRC_W-1:0]      crc_d;
	logic [COORD_W-1:0]    lat_d;
	logic [COORD_W-1:0]    lon_d;
	logic [BYTE_W-1:0]     crc_lo_d;
	logic [CRC_W-1:0]      received;

	assign cfg_ready = 1'b1;
	assign advance   = !m_valid_q || m_tready;
	assign s_tready  = !valid_s1 || advance;
	assign m_tvalid  = m_valid_q;
	assign m_tdata   = m_data_q;
	assign received  = {byte_s1, crc_lo_q};
	assign emit      = valid_s1 && (pos_q == LAST_POS);

	always_comb begin
		pos_d    = pos_q;
		crc_d    = crc_q;
		lat_d    = lat_q;
		lon_d    = lon_q;
		crc_lo_d = crc_lo_q;
		is_data  = 1'b0;
		if (pos_q == '0) begin
			if (byte_s1 == magic_q) begin
				is_data  = 1'b1;
				crc_d    = crc_feed('0, byte_s1);
				lat_d    = '0;
				lon_d    = '0;
				crc_lo_d = '0;
				pos_d    = POS_W'(1);
			end
		end else if (pos_q < DATA_POS) begin
			is_data = 1'b1;
			crc_d   = crc_feed(crc_q, byte_s1);
			pos_d   = pos_q + POS_W'(1);
		end else if (pos_q == DATA_POS) begin
			crc_lo_d = byte_s1;
			pos_d    = LAST_POS;
		end else begin
			pos_d = '0;
		end
		if (is_data) begin
			for (int k = 0; k < 4; k++) begin
				if (pos_q == POS_W'(LAT_OFFSET + k)) begin
					lat_d[8*k +: 8] = byte_s1;
				end
				if (pos_q == POS_W'(LON_OFFSET + k)) begin
					lon_d[8*k +: 8] = byte_s1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q  <= '0;
			valid_s1 <= 1'b0;
			pos_q    <= '0;
			crc_q    <= '0;
			lat_q    <= '0;
			lon_q    <= '0;
			crc_lo_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				magic_q <= cfg_data;
			end
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (valid_s1 && advance) begin
				pos_q    <= pos_d;
				crc_q    <= crc_d;
				lat_q    <= lat_d;
				lon_q    <= lon_d;
				crc_lo_q <= crc_lo_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
		if (emit && advance) begin
			m_data_q <= {{(OUT_DATA_W - OUT_BITS){1'b0}}, crc_q, lon_q, lat_q,
				received != crc_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (advance) begin
			m_valid_q <= emit;
		end
	end

	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		pos_q <= LAST_POS)
		else $error("frame position out of range");

	a_last_rehunt: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && advance) |=> (pos_q == '0) && m_valid_q)
		else $error("last CRC byte did not return to hunting with a result");

	a_crc_out: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && advance) |=> m_data_q[OUT_BITS-1 -: CRC_W] == $past(crc_q))
		else $error("result CRC does not match running CRC");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1 && $stable(byte_s1) && $stable(pos_q))
		else $error("input stage lost a byte under back-pressure");

endmodule

`default_nettype wire
